// ===== rtl/gfba_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the grouped free-block allocator.
package gfba_pkg;

  localparam int BLK_W  = 10;
  localparam int FILL_W = 6;

  localparam int DEF_NUM_BLOCKS = 1024;
  localparam int DEF_GROUP_SIZE = 50;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic capture;
    logic push;
    logic fail;
    logic pop_rd;
    logic pop_take;
    logic mod_start;
    logic mod_step;
    logic base;
    logic copy_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic stack_full;
    logic stack_empty;
    logic stack_one;
    logic leader_zero;
    logic mod_last;
    logic copy_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/gfba_req_if.sv =====
`timescale 1ns / 1ps
// Request channel interface carrying one allocate or free transaction.
interface gfba_req_if import gfba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, opcode, block_number, input ready);
  modport sink (input valid, opcode, block_number, output ready);
endinterface

// ===== rtl/gfba_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel interface carrying one result transaction.
interface gfba_rsp_if import gfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [BLK_W-1:0]  allocated_block;
  logic [FILL_W-1:0] stack_fill;

  modport source (output valid, status, allocated_block, stack_fill, input ready);
  modport sink (input valid, status, allocated_block, stack_fill, output ready);
endinterface

// ===== rtl/grouped_free_block_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the grouped free-block allocator.
// Each request transaction on in_req either allocates a block (opcode 0) or
// frees block_number (opcode 1). Each request yields exactly one response
// transaction on out_rsp with a status, the block handed out and the stack fill.
// A push or a failed allocate passes through the decode and done states, and a
// plain pop through decode, pop and done; in_req.ready rises again in the same
// cycle as the response appears. A free into a full stack (spill) or an
// allocate that takes the group leader (reload) first reduces the group number
// in three steps, then copies the whole group between the stack RAM and the
// group RAM one word per cycle before it moves on to the done state.
// One request is worked on at a time; in_req.ready is high only when idle.
// The response sits in an output register, so a new request is taken while a
// finished response still waits; if the receiver stalls, the block holds the
// next result until the register frees up. After reset the stack holds one
// leader entry of 0, meaning no free block; blocks must be freed first.
// No clearing pass is needed after reset.
module grouped_free_block_allocator import gfba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  gfba_req_if.sink    in_req,
  gfba_rsp_if.source  out_rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gfba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_req.opcode),
    .in_block   (in_req.block_number),
    .out_ready  (out_rsp.ready),
    .out_valid  (out_rsp.valid),
    .out_status (out_rsp.status),
    .out_block  (out_rsp.allocated_block),
    .out_fill   (out_rsp.stack_fill)
  );

endmodule

// ===== rtl/gfba_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gfba_ctrl.sv =====
`timescale 1ns / 1ps
// Control state machine that sequences push, pop, spill and reload operations.
module gfba_ctrl import gfba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_BASE   = 3'd4;
  localparam logic [2:0] S_COPY   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_free) begin
          if (stat.stack_full) begin
            cmd.mod_start = 1'b1;
            state_nxt     = S_MOD;
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_DONE;
          end
        end else if (stat.stack_empty || (stat.stack_one && stat.leader_zero)) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.stack_one) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_DONE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = S_COPY;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/gfba_dp.sv =====
`timescale 1ns / 1ps
// Datapath: free stack, group store, group address unit and result register.
module gfba_dp import gfba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              in_opcode,
  input  logic [BLK_W-1:0]  in_block,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_status,
  output logic [BLK_W-1:0]  out_block,
  output logic [FILL_W-1:0] out_fill
);

  localparam int SCW   = $clog2(GROUP_SIZE + 1);
  localparam int SIW   = $clog2(GROUP_SIZE);
  localparam int GDEP  = NUM_BLOCKS * GROUP_SIZE;
  localparam int GAW   = $clog2(GDEP);
  localparam int MW    = BLK_W + $clog2(NUM_BLOCKS) + 1;
  localparam int KW    = 2;
  localparam int RSH   = BLK_W + $clog2(NUM_BLOCKS);
  localparam int RCW   = BLK_W + 2;
  localparam int PW    = BLK_W + RCW;
  localparam logic [KW-1:0]  K_MUL = KW'(2);
  localparam logic [KW-1:0]  K_SUB = KW'(1);
  localparam logic [KW-1:0]  K_FIX = KW'(0);
  localparam logic [RCW-1:0] RECIP = RCW'((longint'(1) << RSH) / longint'(NUM_BLOCKS));
  localparam logic [MW-1:0]  NB_C  = MW'(NUM_BLOCKS);
  localparam logic [SCW-1:0] GS_C  = SCW'(GROUP_SIZE);

  logic             op_r, op_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [SCW-1:0]   count_r, count_nxt;
  logic [BLK_W-1:0] leader_r, leader_nxt;
  logic [BLK_W-1:0] rem_r, rem_nxt;
  logic [BLK_W-1:0] q_r, q_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [GAW-1:0]   base_r, base_nxt;
  logic [SCW-1:0]   idx_r, idx_nxt;
  logic             res_status_r, res_status_nxt;
  logic [BLK_W-1:0] res_given_r, res_given_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [BLK_W-1:0] out_block_r, out_block_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;

  logic             s_we;
  logic [SIW-1:0]   s_waddr;
  logic [BLK_W-1:0] s_wdata;
  logic [SIW-1:0]   s_raddr;
  logic [BLK_W-1:0] s_rdata;
  logic             g_we;
  logic [GAW-1:0]   g_waddr;
  logic [BLK_W-1:0] g_wdata;
  logic [GAW-1:0]   g_raddr;
  logic [BLK_W-1:0] g_rdata;

  logic [PW-1:0]    mod_prod;
  logic [MW-1:0]    mod_qn;
  logic [MW-1:0]    mod_rem_ext;
  logic [SCW-1:0]   idx_prev;

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (GROUP_SIZE)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (GDEP)
  ) u_group_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // The group number is reduced by a reciprocal multiply, a subtract and one correction.
  assign mod_prod    = PW'(rem_r) * PW'(RECIP);
  assign mod_qn      = MW'(q_r) * NB_C;
  assign mod_rem_ext = MW'(rem_r);
  assign idx_prev    = idx_r - SCW'(1);

  always_comb begin
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    count_nxt      = count_r;
    leader_nxt     = leader_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    k_nxt          = k_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_given_nxt  = res_given_r;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_fill_nxt   = out_fill_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    s_we           = 1'b0;
    s_waddr        = '0;
    s_wdata        = '0;
    s_raddr        = '0;
    g_we           = 1'b0;
    g_waddr        = '0;
    g_wdata        = '0;
    g_raddr        = '0;

    if (cmd.capture) begin
      op_nxt  = in_opcode;
      blk_nxt = in_block;
    end

    if (cmd.push) begin
      if (count_r == '0) begin
        leader_nxt = blk_r;
      end else begin
        s_we    = 1'b1;
        s_waddr = SIW'(count_r);
        s_wdata = blk_r;
      end
      count_nxt      = count_r + SCW'(1);
      res_status_nxt = STATUS_OK;
      res_given_nxt  = '0;
    end

    if (cmd.fail) begin
      res_status_nxt = STATUS_EMPTY;
      res_given_nxt  = '0;
    end

    if (cmd.pop_rd) begin
      s_raddr        = SIW'(count_r - SCW'(1));
      count_nxt      = count_r - SCW'(1);
      res_status_nxt = STATUS_OK;
    end

    if (cmd.pop_take) begin
      res_given_nxt = s_rdata;
    end

    if (cmd.mod_start) begin
      rem_nxt        = (op_r == OP_FREE) ? blk_r : leader_r;
      k_nxt          = K_MUL;
      res_status_nxt = STATUS_OK;
      res_given_nxt  = (op_r == OP_FREE) ? '0 : leader_r;
    end

    if (cmd.mod_step) begin
      case (k_r)
        K_MUL: begin
          q_nxt = BLK_W'(mod_prod >> RSH);
        end
        K_SUB: begin
          rem_nxt = BLK_W'(mod_rem_ext - mod_qn);
        end
        default: begin
          if (mod_rem_ext >= NB_C) begin
            rem_nxt = BLK_W'(mod_rem_ext - NB_C);
          end
        end
      endcase
      k_nxt = k_r - KW'(1);
    end

    if (cmd.base) begin
      base_nxt = GAW'(GAW'(rem_r) * GAW'(GROUP_SIZE));
      idx_nxt  = '0;
    end

    if (cmd.copy_step) begin
      idx_nxt = idx_r + SCW'(1);
      if (op_r == OP_FREE) begin
        s_raddr = (idx_r < GS_C) ? SIW'(idx_r) : '0;
        if (idx_r != '0) begin
          g_we    = 1'b1;
          g_waddr = base_r + GAW'(idx_prev);
          g_wdata = (idx_r == SCW'(1)) ? leader_r : s_rdata;
        end
        if (idx_r == GS_C) begin
          leader_nxt = blk_r;
          count_nxt  = SCW'(1);
        end
      end else begin
        g_raddr = (idx_r < GS_C) ? (base_r + GAW'(idx_r)) : base_r;
        if (idx_r == SCW'(1)) begin
          leader_nxt = g_rdata;
        end else if (idx_r != '0) begin
          s_we    = 1'b1;
          s_waddr = SIW'(idx_prev);
          s_wdata = g_rdata;
        end
        if (idx_r == GS_C) begin
          count_nxt = GS_C;
        end
      end
    end

    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_block_nxt  = res_given_r;
      out_fill_nxt   = FILL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= SCW'(1);
      leader_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      leader_r    <= leader_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    k_r          <= k_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_given_r  <= res_given_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign stat.is_free     = (op_r == OP_FREE);
  assign stat.stack_full  = (count_r >= GS_C);
  assign stat.stack_empty = (count_r == '0);
  assign stat.stack_one   = (count_r == SCW'(1));
  assign stat.leader_zero = (leader_r == '0);
  assign stat.mod_last    = (k_r == K_FIX);
  assign stat.copy_last   = (idx_r == GS_C);
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_block  = out_block_r;
  assign out_fill   = out_fill_r;

endmodule
